>>> hdl/running_mean_stderr_accumulator_unit_macros.svh
// Assertion macros for the running mean / standard error unit.
// Expects clk_i and rst_ni in the scope of use.
`ifndef RUNNING_MEAN_STDERR_ACCUMULATOR_UNIT_MACROS_SVH
`define RUNNING_MEAN_STDERR_ACCUMULATOR_UNIT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define RMSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rmsa assertion failed");

// Same, but with a caller message.
`define RMSA_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

>>> hdl/rmsa_pkg.sv
// Shared types and constants for the running mean / standard error unit.
// No dependencies.
package rmsa_pkg;

  localparam int COUNT_BITS  = 24;
  localparam int WEIGHT_BITS = 16;
  localparam int SUM_BITS    = WEIGHT_BITS + COUNT_BITS;
  localparam int SQ_BITS     = 2 * WEIGHT_BITS + COUNT_BITS;
  localparam int CNT_W       = 6;
  localparam int DIV_STEPS   = SQ_BITS;
  localparam int SQRT_STEPS  = SQ_BITS / 2;

  // opcodes
  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_SCALE = 2'd1;
  localparam logic [1:0] OP_CLR   = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  // datapath commands
  localparam logic [3:0] CMD_NONE    = 4'd0;
  localparam logic [3:0] CMD_ACC     = 4'd1;
  localparam logic [3:0] CMD_CLR     = 4'd2;
  localparam logic [3:0] CMD_SC1     = 4'd3;
  localparam logic [3:0] CMD_SC2     = 4'd4;
  localparam logic [3:0] CMD_SC3     = 4'd5;
  localparam logic [3:0] CMD_SC4     = 4'd6;
  localparam logic [3:0] CMD_D1_INIT = 4'd7;
  localparam logic [3:0] CMD_DIV     = 4'd8;
  localparam logic [3:0] CMD_D1_END  = 4'd9;
  localparam logic [3:0] CMD_D2_INIT = 4'd10;
  localparam logic [3:0] CMD_D2_END  = 4'd11;
  localparam logic [3:0] CMD_D3_END  = 4'd12;
  localparam logic [3:0] CMD_SQRT    = 4'd13;
  localparam logic [3:0] CMD_RESULT  = 4'd14;

  typedef struct packed {
    logic       take;
    logic [3:0] code;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       n_zero;
    logic       se_ok;
  } stat_t;

endpackage

>>> hdl/rmsa_ctrl.sv
// Controller state machine of the running mean / standard error unit.
// Depends on rmsa_pkg.
module rmsa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  rmsa_pkg::stat_t stat_i,
  output rmsa_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_UPD  = 4'd1;
  localparam logic [3:0] S_SC2  = 4'd2;
  localparam logic [3:0] S_SC3  = 4'd3;
  localparam logic [3:0] S_SC4  = 4'd4;
  localparam logic [3:0] S_D1I  = 4'd5;
  localparam logic [3:0] S_D1   = 4'd6;
  localparam logic [3:0] S_D1E  = 4'd7;
  localparam logic [3:0] S_D1C  = 4'd8;
  localparam logic [3:0] S_D2   = 4'd9;
  localparam logic [3:0] S_D2E  = 4'd10;
  localparam logic [3:0] S_D2C  = 4'd11;
  localparam logic [3:0] S_D3   = 4'd12;
  localparam logic [3:0] S_D3E  = 4'd13;
  localparam logic [3:0] S_SQ   = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  localparam logic [rmsa_pkg::CNT_W-1:0] DIV_LAST =
    rmsa_pkg::CNT_W'(rmsa_pkg::DIV_STEPS - 1);
  localparam logic [rmsa_pkg::CNT_W-1:0] SQRT_LAST =
    rmsa_pkg::CNT_W'(rmsa_pkg::SQRT_STEPS - 1);

  logic [3:0]                 state_q, state_d;
  logic [rmsa_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       ovld_q, ovld_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q + 1'b1;
    cmd_o.take = 1'b0;
    cmd_o.code = rmsa_pkg::CMD_NONE;
    ovld_d     = ovld_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_UPD;
        end
      end
      S_UPD: begin
        case (stat_i.op)
          rmsa_pkg::OP_ACC:   cmd_o.code = rmsa_pkg::CMD_ACC;
          rmsa_pkg::OP_SCALE: cmd_o.code = rmsa_pkg::CMD_SC1;
          rmsa_pkg::OP_CLR:   cmd_o.code = rmsa_pkg::CMD_CLR;
          default:            cmd_o.code = rmsa_pkg::CMD_NONE;
        endcase
        state_d = (stat_i.op == rmsa_pkg::OP_SCALE) ? S_SC2 : S_D1I;
      end
      S_SC2: begin
        cmd_o.code = rmsa_pkg::CMD_SC2;
        state_d    = S_SC3;
      end
      S_SC3: begin
        cmd_o.code = rmsa_pkg::CMD_SC3;
        state_d    = S_SC4;
      end
      S_SC4: begin
        cmd_o.code = rmsa_pkg::CMD_SC4;
        state_d    = S_D1I;
      end
      S_D1I: begin
        cnt_d = '0;
        if (stat_i.n_zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o.code = rmsa_pkg::CMD_D1_INIT;
          state_d    = S_D1;
        end
      end
      S_D1: begin
        cmd_o.code = rmsa_pkg::CMD_DIV;
        if (cnt_q == DIV_LAST) state_d = S_D1E;
      end
      S_D1E: begin
        cmd_o.code = rmsa_pkg::CMD_D1_END;
        state_d    = S_D1C;
      end
      S_D1C: begin
        cnt_d = '0;
        if (stat_i.se_ok) begin
          cmd_o.code = rmsa_pkg::CMD_D2_INIT;
          state_d    = S_D2;
        end else begin
          state_d = S_OUT;
        end
      end
      S_D2: begin
        cmd_o.code = rmsa_pkg::CMD_DIV;
        if (cnt_q == DIV_LAST) state_d = S_D2E;
      end
      S_D2E: begin
        cmd_o.code = rmsa_pkg::CMD_D2_END;
        state_d    = S_D2C;
      end
      S_D2C: begin
        cnt_d   = '0;
        state_d = stat_i.se_ok ? S_D3 : S_OUT;
      end
      S_D3: begin
        cmd_o.code = rmsa_pkg::CMD_DIV;
        if (cnt_q == DIV_LAST) state_d = S_D3E;
      end
      S_D3E: begin
        cmd_o.code = rmsa_pkg::CMD_D3_END;
        cnt_d      = '0;
        state_d    = S_SQ;
      end
      S_SQ: begin
        cmd_o.code = rmsa_pkg::CMD_SQRT;
        if (cnt_q == SQRT_LAST) state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovld_q || !out_stall_i) begin
          cmd_o.code = rmsa_pkg::CMD_RESULT;
          ovld_d     = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

>>> hdl/rmsa_dpath.sv
// Datapath: accumulators, scale products, shared divider and square root.
// Depends on rmsa_pkg.
module rmsa_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rmsa_pkg::cmd_t                     cmd_i,
  output rmsa_pkg::stat_t                    stat_o,
  input  logic [1:0]                         opcode_i,
  input  logic [rmsa_pkg::WEIGHT_BITS-1:0]   weight_i,
  input  logic [rmsa_pkg::WEIGHT_BITS-1:0]   factor_i,
  output logic [rmsa_pkg::COUNT_BITS-1:0]    sample_count_o,
  output logic [15:0]                        mean_value_o,
  output logic [15:0]                        std_error_o,
  output logic [rmsa_pkg::WEIGHT_BITS-1:0]   max_weight_o,
  output logic                               overflow_seen_o
);

  localparam int CB = rmsa_pkg::COUNT_BITS;
  localparam int WB = rmsa_pkg::WEIGHT_BITS;
  localparam int SB = rmsa_pkg::SUM_BITS;
  localparam int QB = rmsa_pkg::SQ_BITS;

  // architectural state
  logic [CB-1:0] cnt_q;
  logic [SB-1:0] sum_q;
  logic [QB-1:0] sq_q;
  logic [WB-1:0] max_q;
  logic          ovf_q;
  // captured item
  logic [1:0]    op_q;
  logic [WB-1:0] w_q, f_q;
  // scale products
  logic [2*WB-1:0]  ff_q, ms_q;
  logic [SB+WB-1:0] ps_q;
  logic [63:0]      p0_q;
  logic [QB-1:0]    p1_q;
  // divider / sqrt
  logic [QB-1:0] dvd_q, x_q, r_q, bit_q;
  logic [CB-1:0] rem_q, dvs_q;
  logic [SB-1:0] q_q;
  logic [63:0]   qq_q;
  logic          se_ok_q;
  // outputs
  logic [CB-1:0] o_cnt_q;
  logic [15:0]   o_mean_q, o_se_q;
  logic [WB-1:0] o_max_q;
  logic          o_ovf_q;

  // combinational helpers
  logic [2*WB-1:0] w_sq;
  logic [SB:0]    acc_sum;
  logic [QB:0]    acc_sq;
  logic [SB+WB-9:0] sc_sum;
  logic [2*WB-9:0]  sc_max;
  logic [QB:0]    sc_sq;
  logic [CB:0]    rem_sh;
  logic           rem_ge;
  logic [QB-1:0]  sq_t;
  logic           sq_ge;
  logic           var_pos;
  logic [QB-1:0]  diff;

  always_comb begin
    w_sq    = w_q * w_q;
    acc_sum = {1'b0, sum_q} + {{(SB+1-WB){1'b0}}, w_q};
    acc_sq  = {1'b0, sq_q} + {{(QB+1-2*WB){1'b0}}, w_sq};
    sc_sum  = ps_q[SB+WB-1:8];
    sc_max  = ms_q[2*WB-1:8];
    sc_sq   = {1'b0, p1_q[QB-17:0], 16'h0} + {{(QB+1-48){1'b0}}, p0_q[63:16]};
    rem_sh  = {rem_q, dvd_q[QB-1]};
    rem_ge  = rem_sh >= {1'b0, dvs_q};
    sq_t    = r_q + bit_q;
    sq_ge   = x_q >= sq_t;
    var_pos = {{(64-QB){1'b0}}, dvd_q} > qq_q;
    diff    = dvd_q - qq_q[QB-1:0];
  end

  assign stat_o.op     = op_q;
  assign stat_o.n_zero = (cnt_q == '0);
  assign stat_o.se_ok  = se_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
      max_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      case (cmd_i.code)
        rmsa_pkg::CMD_ACC: begin
          if (acc_sum[SB]) begin
            sum_q <= '1;
          end else begin
            sum_q <= acc_sum[SB-1:0];
          end
          if (acc_sq[QB]) begin
            sq_q <= '1;
          end else begin
            sq_q <= acc_sq[QB-1:0];
          end
          if (w_q > max_q) max_q <= w_q;
          if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
          ovf_q <= ovf_q | acc_sum[SB] | acc_sq[QB] | (cnt_q == '1);
        end
        rmsa_pkg::CMD_CLR: begin
          cnt_q <= '0;
          sum_q <= '0;
          sq_q  <= '0;
          max_q <= '0;
          ovf_q <= 1'b0;
        end
        rmsa_pkg::CMD_SC2: begin
          if (|sc_sum[SB+WB-9:SB]) begin
            sum_q <= '1;
          end else begin
            sum_q <= sc_sum[SB-1:0];
          end
          if (|sc_max[2*WB-9:WB]) begin
            max_q <= '1;
          end else begin
            max_q <= sc_max[WB-1:0];
          end
          ovf_q <= ovf_q | (|sc_sum[SB+WB-9:SB]) | (|sc_max[2*WB-9:WB]);
        end
        rmsa_pkg::CMD_SC4: begin
          if ((|p1_q[QB-1:QB-16]) || sc_sq[QB]) begin
            sq_q  <= '1;
            ovf_q <= 1'b1;
          end else begin
            sq_q <= sc_sq[QB-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      se_ok_q <= 1'b0;
    end else if (cmd_i.take) begin
      se_ok_q <= 1'b0;
    end else if (cmd_i.code == rmsa_pkg::CMD_D1_END) begin
      se_ok_q <= (cnt_q > CB'(1)) && !(|dvd_q[QB-1:32]);
    end else if (cmd_i.code == rmsa_pkg::CMD_D2_END) begin
      se_ok_q <= se_ok_q && var_pos;
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q <= opcode_i;
      w_q  <= weight_i;
      f_q  <= factor_i;
    end
    case (cmd_i.code)
      rmsa_pkg::CMD_SC1: begin
        ff_q <= f_q * f_q;
        ms_q <= max_q * f_q;
        ps_q <= sum_q * f_q;
      end
      rmsa_pkg::CMD_SC2: p0_q <= sq_q[31:0] * ff_q;
      rmsa_pkg::CMD_SC3: p1_q <= QB'(sq_q[QB-1:32] * ff_q);
      rmsa_pkg::CMD_D1_INIT: begin
        dvd_q <= {{(QB-SB){1'b0}}, sum_q};
        dvs_q <= cnt_q;
        rem_q <= '0;
      end
      rmsa_pkg::CMD_DIV: begin
        rem_q <= rem_ge ? CB'(rem_sh - {1'b0, dvs_q}) : rem_sh[CB-1:0];
        dvd_q <= {dvd_q[QB-2:0], rem_ge};
      end
      rmsa_pkg::CMD_D1_END: begin
        q_q  <= dvd_q[SB-1:0];
        qq_q <= dvd_q[31:0] * dvd_q[31:0];
      end
      rmsa_pkg::CMD_D2_INIT: begin
        dvd_q <= sq_q;
        dvs_q <= cnt_q;
        rem_q <= '0;
      end
      rmsa_pkg::CMD_D2_END: begin
        dvd_q <= diff;
        dvs_q <= cnt_q - 1'b1;
        rem_q <= '0;
      end
      rmsa_pkg::CMD_D3_END: begin
        // top power of four below 2^QB, one step per radicand bit pair
        x_q   <= dvd_q;
        r_q   <= '0;
        bit_q <= {2'b01, {(QB-2){1'b0}}};
      end
      rmsa_pkg::CMD_SQRT: begin
        if (sq_ge) begin
          x_q <= x_q - sq_t;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      rmsa_pkg::CMD_RESULT: begin
        o_cnt_q  <= cnt_q;
        o_max_q  <= max_q;
        o_ovf_q  <= ovf_q;
        if (cnt_q == '0) o_mean_q <= '0;
        else o_mean_q <= (|q_q[SB-1:16]) ? 16'hFFFF : q_q[15:0];
        if (!se_ok_q) o_se_q <= '0;
        else o_se_q <= (|r_q[QB-1:16]) ? 16'hFFFF : r_q[15:0];
      end
      default: ;
    endcase
  end

  assign sample_count_o  = o_cnt_q;
  assign mean_value_o    = o_mean_q;
  assign std_error_o     = o_se_q;
  assign max_weight_o    = o_max_q;
  assign overflow_seen_o = o_ovf_q;

endmodule

>>> hdl/running_mean_stderr_accumulator_unit.sv
// Top level of the running mean / standard error unit.
// Depends on rmsa_pkg, rmsa_ctrl and rmsa_dpath.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries opcode_i, weight_i and
//    factor_i: accumulate, scale, clear or query. One result per transfer.
//  - Output channel (out_valid_o / out_stall_i) returns count, mean,
//    standard error, maximum and the sticky overflow flag after the item.
//  - One item at a time. The update follows the transfer (scale adds the
//    product states SC2, SC3, SC4); then a 56-step shared restoring divider
//    runs up to three times (sum/n, sumsq/n, variance/(n-1)) and a 28-step
//    square root follows. An empty accumulator skips the divisions and the
//    square root; one sample or a non-positive variance skips the later
//    divisions and the square root.
//  - The next transfer can be taken in the cycle after the result write.
//  - The output register holds a finished result; the next item may be
//    taken while it waits, but the result write waits for the receiver.
//  - Reset clears all accumulators and the overflow flag; no output valid.
module running_mean_stderr_accumulator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       opcode_i,
  input  logic [rmsa_pkg::WEIGHT_BITS-1:0] weight_i,
  input  logic [rmsa_pkg::WEIGHT_BITS-1:0] factor_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rmsa_pkg::COUNT_BITS-1:0]  sample_count_o,
  output logic [15:0]                      mean_value_o,
  output logic [15:0]                      std_error_o,
  output logic [rmsa_pkg::WEIGHT_BITS-1:0] max_weight_o,
  output logic                             overflow_seen_o
);

  rmsa_pkg::cmd_t  cmd;
  rmsa_pkg::stat_t stat;

  rmsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rmsa_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .opcode_i        (opcode_i),
    .weight_i        (weight_i),
    .factor_i        (factor_i),
    .sample_count_o  (sample_count_o),
    .mean_value_o    (mean_value_o),
    .std_error_o     (std_error_o),
    .max_weight_o    (max_weight_o),
    .overflow_seen_o (overflow_seen_o)
  );

endmodule

>>> hdl/rmsa_checker.sv
// Port-level checks for the running mean / standard error unit, bound to top.
// Depends on rmsa_pkg and the macros header.
`include "running_mean_stderr_accumulator_unit_macros.svh"

module rmsa_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic [1:0]                       opcode_i,
  input logic [rmsa_pkg::WEIGHT_BITS-1:0] weight_i,
  input logic [rmsa_pkg::WEIGHT_BITS-1:0] factor_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [rmsa_pkg::COUNT_BITS-1:0]  sample_count_o,
  input logic [15:0]                      mean_value_o,
  input logic [15:0]                      std_error_o,
  input logic [rmsa_pkg::WEIGHT_BITS-1:0] max_weight_o,
  input logic                             overflow_seen_o
);

  // a transfer in makes the unit busy on the next cycle
  `RMSA_ASSERT(a_busy_after_take, in_valid_i && !in_stall_o |=> in_stall_o)
  // a stalled result stays
  `RMSA_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(mean_value_o))
  // empty accumulator gives zero mean and error
  `RMSA_ASSERT_MSG(a_empty_zero, out_valid_o && sample_count_o == '0 |-> mean_value_o == '0 && std_error_o == '0, "empty result not zero")
  // a single sample gives zero error
  `RMSA_ASSERT_MSG(a_single_zero, out_valid_o && sample_count_o == 24'd1 |-> std_error_o == '0, "single sample error")

endmodule

bind running_mean_stderr_accumulator_unit rmsa_checker u_rmsa_checker (.*);

>>> dv/running_mean_stderr_accumulator_unit_checker.sv
// Result checker for the running mean / standard error unit.
// Watches both channels, keeps its own copy of the accumulator state and
// compares every result transfer. Depends on rmsa_pkg.
module running_mean_stderr_accumulator_unit_checker
  import rmsa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [1:0]             opcode_i,
  input  logic [WEIGHT_BITS-1:0] weight_i,
  input  logic [WEIGHT_BITS-1:0] factor_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [COUNT_BITS-1:0]  sample_count_i,
  input  logic [15:0]            mean_value_i,
  input  logic [15:0]            std_error_i,
  input  logic [WEIGHT_BITS-1:0] max_weight_i,
  input  logic                   overflow_seen_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [COUNT_BITS-1:0]  count;
    logic [15:0]            mean;
    logic [15:0]            stderr;
    logic [WEIGHT_BITS-1:0] maxw;
    logic                   ovf;
  } stats_t;

  localparam logic [63:0] SUM_TOP = (64'd1 << SUM_BITS) - 1;
  localparam logic [63:0] SQ_TOP  = (64'd1 << SQ_BITS) - 1;
  localparam logic [63:0] CNT_TOP = (64'd1 << COUNT_BITS) - 1;
  localparam logic [63:0] W_TOP   = (64'd1 << WEIGHT_BITS) - 1;

  logic [63:0] acc_n, acc_sum, acc_sq, acc_max;
  logic        acc_ovf;
  stats_t      expected_stats[$];
  int          fails;
  int          pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Applies one item to the shadow state and returns the stats it reports.
  function automatic stats_t apply_item(logic [1:0] op, logic [63:0] w, logic [63:0] f);
    logic [63:0]  s, t, m, q, qq, v, se, mean;
    logic [127:0] wide;
    stats_t       r;
    mean = 0;
    se   = 0;
    case (op)
      OP_ACC: begin
        if (w > W_TOP) begin
          w = W_TOP;
          acc_ovf = 1;
        end
        s = acc_sum + w;
        if (s > SUM_TOP) begin
          s = SUM_TOP;
          acc_ovf = 1;
        end
        acc_sum = s;
        t = acc_sq + w * w;
        if (t > SQ_TOP) begin
          t = SQ_TOP;
          acc_ovf = 1;
        end
        acc_sq = t;
        if (w > acc_max) acc_max = w;
        if (acc_n < CNT_TOP) acc_n++;
        else acc_ovf = 1;
      end
      OP_SCALE: begin
        s = (acc_sum * f) >> 8;
        m = (acc_max * f) >> 8;
        if (s > SUM_TOP) begin
          s = SUM_TOP;
          acc_ovf = 1;
        end
        acc_sum = s;
        wide = ({64'd0, acc_sq} * {64'd0, f * f}) >> 16;
        if (wide > {64'd0, SQ_TOP}) begin
          acc_sq = SQ_TOP;
          acc_ovf = 1;
        end else begin
          acc_sq = wide[63:0];
        end
        if (m > W_TOP) begin
          m = W_TOP;
          acc_ovf = 1;
        end
        acc_max = m;
      end
      OP_CLR: begin
        acc_n = 0; acc_sum = 0; acc_sq = 0; acc_max = 0; acc_ovf = 0;
      end
      default: ;
    endcase
    if (acc_n > 0) begin
      q    = acc_sum / acc_n;
      mean = (q > 64'hFFFF) ? 64'hFFFF : q;
      // variance only when the squared mean fits
      if (acc_n > 1 && q[63:32] == 0) begin
        m  = acc_sq / acc_n;
        qq = q * q;
        if (m > qq) begin
          v  = (m - qq) / (acc_n - 1);
          se = floor_sqrt(v);
          if (se > 64'hFFFF) se = 64'hFFFF;
        end
      end
    end
    r.count  = acc_n[COUNT_BITS-1:0];
    r.mean   = mean[15:0];
    r.stderr = se[15:0];
    r.maxw   = acc_max[WEIGHT_BITS-1:0];
    r.ovf    = acc_ovf;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stats_t e;
    if (!rst_ni) begin
      acc_n = 0; acc_sum = 0; acc_sq = 0; acc_max = 0; acc_ovf = 0;
      expected_stats.delete();
      fails   = 0;
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_stats.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          e = expected_stats.pop_front();
          pending--;
          if (sample_count_i !== e.count) begin
            $error("sample_count exp %0d got %0d", e.count, sample_count_i);
            fails++;
          end
          if (mean_value_i !== e.mean) begin
            $error("mean_value exp %0d got %0d", e.mean, mean_value_i);
            fails++;
          end
          if (std_error_i !== e.stderr) begin
            $error("std_error exp %0d got %0d", e.stderr, std_error_i);
            fails++;
          end
          if (max_weight_i !== e.maxw) begin
            $error("max_weight exp %0d got %0d", e.maxw, max_weight_i);
            fails++;
          end
          if (overflow_seen_i !== e.ovf) begin
            $error("overflow_seen exp %0d got %0d", e.ovf, overflow_seen_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_stats.push_back(apply_item(opcode_i, 64'(weight_i), 64'(factor_i)));
        pending++;
      end
    end
  end

endmodule

>>> dv/running_mean_stderr_accumulator_unit_tb.sv
// Testbench top for the running mean / standard error unit.
// Drives directed and random opcode streams with bursty input and a
// stalling receiver; checking lives in running_mean_stderr_accumulator_unit_checker.
module running_mean_stderr_accumulator_unit_tb;
  import rmsa_pkg::*;

  localparam int IDLE_LIMIT = 5000;  // cycles with no transfer before giving up
  localparam int DRAIN_WAIT = 250;   // slightly above the full result path

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             opcode_i = OP_QUERY;
  logic [WEIGHT_BITS-1:0] weight_i = '0;
  logic [WEIGHT_BITS-1:0] factor_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [COUNT_BITS-1:0]  sample_count_o;
  logic [15:0]            mean_value_o;
  logic [15:0]            std_error_o;
  logic [WEIGHT_BITS-1:0] max_weight_o;
  logic                   overflow_seen_o;
  int                     fail_count, pending;
  int                     idle_cycles = 0;
  int                     burst_left;

  always #4 clk_i = ~clk_i;

  running_mean_stderr_accumulator_unit dut (.*);

  running_mean_stderr_accumulator_unit_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .weight_i,
    .factor_i, .out_valid_i(out_valid_o), .out_stall_i, .sample_count_i(sample_count_o),
    .mean_value_i(mean_value_o), .std_error_i(std_error_o), .max_weight_i(max_weight_o),
    .overflow_seen_i(overflow_seen_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stall pattern: modes of random length - open, choppy, long holds.
  initial begin
    int mode, span;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 400);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0: out_stall_i = 1'b0;
          1: out_stall_i = ($urandom_range(0, 1) == 1);
          default: out_stall_i = ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  // Watchdog: any transfer on either side clears the idle count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One input transfer; bursts of back-to-back items separated by random gaps.
  task automatic send_item(logic [1:0] op, logic [WEIGHT_BITS-1:0] w,
                           logic [WEIGHT_BITS-1:0] f);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    opcode_i   = op;
    weight_i   = w;
    factor_i   = f;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [WEIGHT_BITS-1:0] rand_weight();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 255));
      1: return 16'($urandom_range(16'h0F00, 16'h1100));
      2: return 16'($urandom);
      default: return 16'($urandom_range(16'hFF00, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [WEIGHT_BITS-1:0] rand_factor();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(16'h00C0, 16'h0140));
    endcase
  endfunction

  initial begin
    int sent, run;
    burst_left  = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty query, single sample, extremes, flat data, saturation.
    send_item(OP_QUERY, 16'hFFFF, 16'hFFFF);
    send_item(OP_ACC,   16'h0000, 16'hFFFF);
    send_item(OP_QUERY, 16'h0000, 16'h0000);
    send_item(OP_ACC,   16'hFFFF, 16'h0000);
    send_item(OP_ACC,   16'h0001, 16'h1234);
    send_item(OP_SCALE, 16'h5555, 16'h0100);
    send_item(OP_SCALE, 16'h0000, 16'h0080);
    send_item(OP_CLR,   16'hAAAA, 16'h5555);
    send_item(OP_ACC,   16'h0300, 16'h0000);
    send_item(OP_ACC,   16'h0300, 16'h0000);
    send_item(OP_ACC,   16'h0300, 16'h0000);
    // repeated large scaling drives the sums and maximum into saturation
    repeat (6) send_item(OP_SCALE, 16'h0000, 16'hFFFF);
    send_item(OP_ACC,   16'hFFFF, 16'h0000);
    send_item(OP_QUERY, 16'h0000, 16'h0000);
    send_item(OP_SCALE, 16'h0000, 16'h0000);
    send_item(OP_CLR,   16'h0000, 16'h0000);
    send_item(OP_QUERY, 16'h0000, 16'h0000);
    sent = 22;

    // Random: usually a clear, then a run of samples with occasional scales and queries.
    while (sent < 1100) begin
      if ($urandom_range(0, 3) != 0) begin
        send_item(OP_CLR, 16'($urandom), 16'($urandom));
        sent++;
      end
      run = $urandom_range(1, 40);
      repeat (run) begin
        case ($urandom_range(0, 15))
          0:       send_item(OP_SCALE, 16'($urandom), rand_factor());
          1:       send_item(OP_QUERY, 16'($urandom), 16'($urandom));
          default: send_item(OP_ACC, rand_weight(), 16'($urandom));
        endcase
        sent++;
      end
    end
    in_valid_i = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
